@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every rising edge outside reset
`define PRL_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("rate limiter property violated");

// check that an antecedent is followed by a consequent in the next cycle
`define PRL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rate limiter sequence violated");

`endif

@@ rtl/prl_pkg.sv @@
// Types, constants and register codes of the per-client rate limiter.
// No dependencies; imported by every module of the block.
package prl_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W        = 32;
	localparam int TIME_W        = 32;
	localparam int COUNT_W       = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int FREED_W       = 7;

	localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE    = COUNT_W'(1);
	localparam logic [CFG_W-1:0]   RESET_LIMIT  = CFG_W'(60);
	localparam logic [CFG_W-1:0]   RESET_WINDOW = CFG_W'(60);

	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = CFG_IDX_W'(1);

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_SWEEP   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] client_addr;
		logic [TIME_W-1:0] now_sec;
	} req_t;

	typedef struct packed {
		logic               allowed;
		logic [COUNT_W-1:0] request_count;
		logic               table_full;
		logic [FREED_W-1:0] freed_entries;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [TIME_W-1:0]  start;
		logic [COUNT_W-1:0] count;
	} entry_t;

	typedef struct packed {
		logic             mem_we;
		logic             vld_set;
		logic             vld_clr;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} tbl_wr_t;

endpackage

@@ rtl/per_client_rate_limiter.sv @@
// Per-client fixed-window rate limiter, top level with the scan sequencer.
// Sequence: a beat taken in idle starts a scan, then resolve loads the result register
// once the output is free. Beats are stalled until then; the single table read port walks
// one entry a cycle through the shared expiry unit.
// Reset: valid bits cleared at once, limits return to 60; no clearing pass.
// Depends on prl_pkg, prl_table and prl_expiry.
module per_client_rate_limiter import prl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	state_t             state_q, state_d;
	req_t               item_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               issue_q;
	logic               scan_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	entry_t             hit_data_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [FREED_W-1:0] freed_q;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_valid_q;
	logic [CFG_W-1:0]   max_req_q;
	logic [CFG_W-1:0]   window_q;

	tbl_wr_t            tbl_wr;
	entry_t             rd_data;
	logic               rd_valid;
	logic [TIME_W-1:0]  exp_start;
	logic               expired;
	logic               scan_start;
	logic               rsp_load;
	logic               proceed;
	logic               is_sweep;
	logic [COUNT_W-1:0] new_count;

	prl_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_idx   (rd_idx_q),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	assign exp_start = (state_q == ST_RESOLVE) ? hit_data_q.start : rd_data.start;

	prl_expiry u_expiry (
		.now_sec (item_q.now_sec),
		.start   (exp_start),
		.window  (window_q),
		.expired (expired)
	);

	assign is_sweep = (item_q.action == ACT_SWEEP);
	assign proceed  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (expired) begin
			new_count = COUNT_ONE;
		end else if (hit_data_q.count != COUNT_MAX) begin
			new_count = hit_data_q.count + COUNT_ONE;
		end else begin
			new_count = hit_data_q.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		tbl_wr     = '0;
		tbl_wr.idx = idx_s1;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					scan_start = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_vld_s1 && is_sweep && rd_valid && expired) begin
					tbl_wr.vld_clr = 1'b1;
				end
				if (scan_vld_s1 && (idx_s1 == LAST_IDX)) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				if (proceed) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
					if (is_sweep) begin
						rsp_d.allowed       = 1'b1;
						rsp_d.freed_entries = freed_q;
					end else if (hit_q) begin
						tbl_wr.mem_we     = 1'b1;
						tbl_wr.idx        = hit_idx_q;
						tbl_wr.data.addr  = hit_data_q.addr;
						tbl_wr.data.start = expired ? item_q.now_sec : hit_data_q.start;
						tbl_wr.data.count = new_count;
						rsp_d.request_count = new_count;
						rsp_d.allowed       = (new_count <= max_req_q);
					end else if (free_q) begin
						tbl_wr.mem_we     = 1'b1;
						tbl_wr.vld_set    = 1'b1;
						tbl_wr.idx        = free_idx_q;
						tbl_wr.data.addr  = item_q.client_addr;
						tbl_wr.data.start = item_q.now_sec;
						tbl_wr.data.count = COUNT_ONE;
						rsp_d.request_count = COUNT_ONE;
						rsp_d.allowed       = (COUNT_ONE <= max_req_q);
					end else begin
						rsp_d.request_count = COUNT_ONE;
						rsp_d.table_full    = 1'b1;
						rsp_d.allowed       = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			item_q <= req;
		end
		idx_s1 <= rd_idx_q;
		if (scan_vld_s1 && !is_sweep) begin
			if (rd_valid && (rd_data.addr == item_q.client_addr) && !hit_q) begin
				hit_idx_q  <= idx_s1;
				hit_data_q <= rd_data;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			issue_q     <= 1'b0;
			scan_vld_s1 <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			freed_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= issue_q;
			if (scan_start) begin
				rd_idx_q <= '0;
				issue_q  <= 1'b1;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
				freed_q  <= '0;
			end else begin
				if (issue_q) begin
					if (rd_idx_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				if (scan_vld_s1) begin
					if (is_sweep) begin
						if (rd_valid && expired) begin
							freed_q <= freed_q + 1'b1;
						end
					end else begin
						if (rd_valid && (rd_data.addr == item_q.client_addr)) begin
							hit_q <= 1'b1;
						end
						if (!rd_valid) begin
							free_q <= 1'b1;
						end
					end
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q <= RESET_LIMIT;
			window_q  <= RESET_WINDOW;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_REQUESTS:   max_req_q <= cfg_data;
				REG_WINDOW_SECONDS: window_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

endmodule

@@ rtl/prl_table.sv @@
// Client table: address, window start and count memory plus per-entry valid bits.
// Depends on prl_pkg; one write port, one registered read port.
module prl_table import prl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  tbl_wr_t          wr,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data,
	output logic             rd_valid
);

	entry_t                   mem [TABLE_ENTRIES];
	entry_t                   rd_data_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.mem_we) begin
			mem[wr.idx] <= wr.data;
		end
		rd_data_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.vld_set) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (wr.vld_clr) begin
				valid_q[wr.idx] <= 1'b0;
			end
			rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

@@ rtl/prl_expiry.sv @@
// Shared window expiry unit: wrapping elapsed time compared with the window length.
// Depends on prl_pkg.
module prl_expiry import prl_pkg::*; (
	input  logic [TIME_W-1:0] now_sec,
	input  logic [TIME_W-1:0] start,
	input  logic [CFG_W-1:0]  window,
	output logic              expired
);

	logic [TIME_W-1:0] elapsed;

	assign elapsed = now_sec - start;
	assign expired = elapsed > TIME_W'(window);

endmodule

@@ rtl/prl_checker.sv @@
// Port-level checker for the rate limiter, bound to the top level.
// Depends on prl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module prl_checker import prl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic full_ok;
	logic sweep_ok;

	assign full_ok  = rsp.allowed && (rsp.request_count == COUNT_ONE)
		&& (rsp.freed_entries == '0);
	assign sweep_ok = rsp.allowed && (rsp.request_count == '0) && !rsp.table_full;

	`PRL_ASSERT_NEXT(a_busy_after_beat, req_valid && !req_stall, req_stall)
	`PRL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`PRL_ASSERT(a_full_result, !(rsp_valid && rsp.table_full) || full_ok)
	`PRL_ASSERT(a_sweep_result, !(rsp_valid && (rsp.freed_entries != '0)) || sweep_ok)

endmodule

bind per_client_rate_limiter prl_checker u_prl_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the per-client rate limiter. A scoreboard keeps its own client
// table and limits, predicts every verdict and sweep count, and checks each result beat.
// Depends on prl_pkg and the per_client_rate_limiter RTL.

package rate_check_pkg;
	import prl_pkg::*;

	class verdict_board;
		logic [CFG_W-1:0]   limit;
		logic [CFG_W-1:0]   window;
		bit                 used   [TABLE_ENTRIES];
		logic [ADDR_W-1:0]  owner  [TABLE_ENTRIES];
		logic [TIME_W-1:0]  opened [TABLE_ENTRIES];
		logic [COUNT_W-1:0] hits   [TABLE_ENTRIES];
		rsp_t               verdicts_due [$];
		int                 mismatches;
		int                 results_seen;
		int                 requests;
		int                 sweeps;
		int                 denials;
		int                 overflows;
		int                 freed_total;

		function new();
			limit = RESET_LIMIT;
			window = RESET_WINDOW;
			foreach (used[i]) used[i] = 1'b0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
			if (index == REG_MAX_REQUESTS) limit = value;
			else if (index == REG_WINDOW_SECONDS) window = value;
		endfunction

		function bit expired(int idx, logic [TIME_W-1:0] now);
			logic [TIME_W-1:0] elapsed;
			elapsed = now - opened[idx];
			return elapsed > TIME_W'(window);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("MISMATCH %s", what);
		endfunction

		// predict the verdict of an accepted request or sweep beat
		function void take_request(req_t item);
			rsp_t v;
			int   hit;
			int   spare;
			v = '0;
			if (item.action == ACT_SWEEP) begin
				v.allowed = 1'b1;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (used[i] && expired(i, item.now_sec)) begin
						used[i] = 1'b0;
						v.freed_entries = v.freed_entries + 1'b1;
					end
				end
				sweeps++;
				freed_total += v.freed_entries;
			end else begin
				hit = -1;
				spare = -1;
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (used[i]) begin
						if (hit < 0 && owner[i] == item.client_addr) hit = i;
					end else if (spare < 0) begin
						spare = i;
					end
				end
				if (hit >= 0) begin
					if (expired(hit, item.now_sec)) begin
						hits[hit] = COUNT_ONE;
						opened[hit] = item.now_sec;
					end else if (hits[hit] != COUNT_MAX) begin
						hits[hit] = hits[hit] + COUNT_ONE;
					end
					v.request_count = hits[hit];
				end else if (spare >= 0) begin
					used[spare] = 1'b1;
					owner[spare] = item.client_addr;
					opened[spare] = item.now_sec;
					hits[spare] = COUNT_ONE;
					v.request_count = COUNT_ONE;
				end else begin
					v.request_count = COUNT_ONE;
					v.table_full = 1'b1;
				end
				v.allowed = v.table_full || (v.request_count <= limit);
				requests++;
				if (!v.allowed) denials++;
				if (v.table_full) overflows++;
			end
			verdicts_due.push_back(v);
		endfunction

		function void check_verdict(rsp_t got);
			rsp_t want;
			results_seen++;
			if (verdicts_due.size() == 0) begin
				flag($sformatf("beat %0d arrived with no verdict outstanding", results_seen));
				return;
			end
			want = verdicts_due.pop_front();
			if (got.allowed !== want.allowed || got.request_count !== want.request_count
					|| got.table_full !== want.table_full
					|| got.freed_entries !== want.freed_entries)
				flag($sformatf({"beat %0d allowed/count/full/freed: ",
					"expected %0b/%0d/%0b/%0d, got %0b/%0d/%0b/%0d"}, results_seen,
					want.allowed, want.request_count, want.table_full, want.freed_entries,
					got.allowed, got.request_count, got.table_full, got.freed_entries));
		endfunction

		function void close_out();
			if (verdicts_due.size() != 0)
				flag($sformatf("%0d verdicts never arrived", verdicts_due.size()));
		endfunction
	endclass
endpackage

module testbench;
	import prl_pkg::*;
	import rate_check_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
	localparam int SEGMENTS      = 7;
	localparam int SEGMENT_BEATS = 225;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	verdict_board      board;
	int                idle_pct = 14;
	int                stall_pct = 66;
	int                beats_sent = 0;
	int                cycle_count = 0;
	logic [TIME_W-1:0] now_s = '0;
	logic [ADDR_W-1:0] pool [8];

	per_client_rate_limiter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) board.check_verdict(rsp);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("per_client_rate_limiter verification failed");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_register(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic issue(input logic act, input logic [ADDR_W-1:0] addr,
			input logic [TIME_W-1:0] when);
		req_t item;
		item.action = act;
		item.client_addr = addr;
		item.now_sec = when;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		board.take_request(item);
		beats_sent++;
	endtask

	// drop valid, wait out every verdict, then let the scan pipeline drain
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int               kind;
		int               span;
		int               picks;
		logic [CFG_W-1:0] lim;
		logic [CFG_W-1:0] win;
		board = new();
		foreach (pool[i]) pool[i] = $urandom();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset limits: a window of 60 seconds
		issue(ACT_REQUEST, '0, '0);
		issue(ACT_SWEEP, '1, 32'd60);
		issue(ACT_SWEEP, '0, 32'd61);
		settle();

		write_register(REG_MAX_REQUESTS, 16'd2);
		write_register(REG_WINDOW_SECONDS, 16'd5);
		issue(ACT_REQUEST, 32'h0, 32'd0);
		issue(ACT_REQUEST, 32'h0, 32'd1);
		issue(ACT_REQUEST, 32'h0, 32'd2);
		issue(ACT_REQUEST, '1, '1);
		issue(ACT_REQUEST, 32'h0, 32'd5);
		issue(ACT_REQUEST, 32'h0, 32'd6);
		issue(ACT_REQUEST, '1, 32'd3);
		issue(ACT_REQUEST, 32'h5555_5555, 32'hAAAA_AAAA);
		issue(ACT_REQUEST, 32'hAAAA_AAAA, 32'h5555_5555);
		issue(ACT_SWEEP, 32'h1234_5678, 32'd12);
		issue(ACT_SWEEP, '0, 32'd12);
		issue(ACT_REQUEST, 32'h0, 32'd12);
		settle();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			idle_pct = (seg < 3) ? 14 : (seg < 5) ? 66 : 0;
			stall_pct = (seg < 3) ? 66 : (seg < 5) ? 14 : 0;
			case (seg)
				0: begin lim = '0; win = 16'd1; end
				1: begin lim = '1; win = '1; end
				2: begin lim = 16'd3; win = 16'd8; end
				3: begin lim = 16'd1; win = '1; end
				4: begin lim = '1; win = 16'd1; end
				5: begin
					lim = CFG_W'($urandom_range(2, 12));
					win = CFG_W'($urandom_range(2, 40));
				end
				default: begin
					lim = CFG_W'($urandom_range(0, 65535));
					win = CFG_W'($urandom_range(1, 65535));
				end
			endcase
			write_register(REG_MAX_REQUESTS, lim);
			write_register(REG_WINDOW_SECONDS, win);

			beats_sent = 0;
			while (beats_sent < SEGMENT_BEATS) begin
				kind = $urandom_range(99);
				if (kind < 55) begin
					// hammer a few known clients within and across the window
					span = $urandom_range(6, 30);
					picks = $urandom_range(1, 4);
					repeat (span) begin
						now_s += $urandom_range(0, 2);
						if ($urandom_range(15) == 0)
							issue(ACT_SWEEP, $urandom(), now_s);
						else
							issue(ACT_REQUEST, pool[$urandom_range(picks - 1)], now_s);
					end
				end else if (kind < 63) begin
					// flood with 60 to 72 fresh clients, which can overflow the table
					span = $urandom_range(60, 72);
					repeat (span) issue(ACT_REQUEST, $urandom(), now_s);
					repeat ($urandom_range(1, 4))
						issue(ACT_REQUEST, pool[$urandom_range(7)], now_s);
				end else if (kind < 85) begin
					case ($urandom_range(3))
						0: now_s += TIME_W'(board.window);
						1: now_s += TIME_W'(board.window) + 1;
						2: now_s += $urandom_range(0, board.window);
						default: now_s = 32'hFFFF_FFFF - $urandom_range(0, 40);
					endcase
					issue(ACT_SWEEP, $urandom(), now_s);
					pool[$urandom_range(7)] = $urandom();
				end else begin
					if ($urandom_range(3) == 0) now_s = $urandom();
					issue(1'($urandom_range(1)),
						$urandom_range(1) ? $urandom() : pool[$urandom_range(7)],
						$urandom_range(1) ? now_s : $urandom());
				end
			end
			settle();
		end

		board.close_out();
		$display("Checked %0d requests (%0d refused, %0d with the table full) and %0d sweeps",
			board.requests, board.denials, board.overflows, board.sweeps);
		$display("freeing %0d entries, over %0d limit/window settings and three idle mixes.",
			board.freed_total, SEGMENTS + 2);
		if (board.mismatches == 0) begin
			$display("per_client_rate_limiter verification clean");
		end else begin
			$display("per_client_rate_limiter verification failed");
		end
		$finish;
	end
endmodule
